[rtl/pajte_pkg.sv]
// Shared types, constants and register codes of the peak-aware job timing and energy block.
`default_nettype none

package pajte_pkg;

    // Field and register widths
    localparam int PEAK_W     = 24;
    localparam int RATE_W     = 16;
    localparam int FIELD_W    = 16;
    localparam int OUT_TIME_W = 24;
    localparam int COST_W     = 48;
    localparam int TOTAL_W    = 56;

    // Configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_ADDR_W-1:0] REG_PEAK_START    = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_PEAK_END      = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_RATE_ON_PEAK  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_RATE_OFF_PEAK = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_SPEED_MODE0   = 3'd4;

    localparam logic [RATE_W-1:0]  RATE_RESET  = 16'd256;
    localparam logic [FIELD_W-1:0] SPEED_RESET = 16'd4096;

    // Speed factors and consumption factors carry 12 fraction bits
    localparam int FRAC_BITS = 12;
    localparam int DIV_STEPS = FIELD_W + FRAC_BITS;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    // Pricing: four 32x16 partial products, then a byte-serial divide by six
    localparam int MUL_X_W   = 32;
    localparam int MUL_P_W   = MUL_X_W + FIELD_W;
    localparam int ACC_W     = 80;
    localparam int MAC_STEPS = 4;
    localparam int QUO_W     = 56;
    localparam int D6_STEPS  = QUO_W / 8;
    // floor(x * 683 / 4096) == floor(x / 6) for every x below 1536
    localparam int RECIP6    = 683;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DIV,
        S_CEIL,
        S_DUR,
        S_START,
        S_END,
        S_ON,
        S_SPAN,
        S_OFF,
        S_PB,
        S_PA,
        S_PM,
        S_PC,
        S_PSAT,
        S_PD6,
        S_PADD,
        S_DONE
    } t_state;

    typedef struct packed {
        t_state           state;
        logic [CNT_W-1:0] cnt;
        logic             phase;   // 0: on-peak part, 1: off-peak part
        logic             take;    // request accepted this cycle
    } t_ctrl;

    typedef struct packed {
        logic [PEAK_W-1:0] peak_start;
        logic [PEAK_W-1:0] peak_end;
        logic [RATE_W-1:0] rate_on_peak;
        logic [RATE_W-1:0] rate_off_peak;
    } t_cfg;

    typedef struct packed {
        logic [OUT_TIME_W-1:0] start_time;
        logic [OUT_TIME_W-1:0] end_time;
        logic [COST_W-1:0]     on_peak_cost;
        logic [COST_W-1:0]     off_peak_cost;
        logic [OUT_TIME_W-1:0] makespan;
        logic [TOTAL_W-1:0]    total_cost;
    } t_result;

endpackage

`default_nettype wire

[rtl/pajte_seq.sv]
// Sequencer that steps one job through division, timing and pricing.
`default_nettype none

module pajte_seq (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  wire logic           i_out_free,
    input  wire logic           i_sat,
    output pajte_pkg::t_ctrl    o_ctrl,
    output logic                o_ready,
    output logic                o_load
);

    localparam logic [pajte_pkg::CNT_W-1:0] DIV_LAST =
        pajte_pkg::CNT_W'(pajte_pkg::DIV_STEPS - 1);
    localparam logic [pajte_pkg::CNT_W-1:0] MAC_LAST =
        pajte_pkg::CNT_W'(pajte_pkg::MAC_STEPS - 1);
    localparam logic [pajte_pkg::CNT_W-1:0] D6_LAST =
        pajte_pkg::CNT_W'(pajte_pkg::D6_STEPS - 1);

    pajte_pkg::t_state            r_state, n_state;
    logic [pajte_pkg::CNT_W-1:0]  r_cnt, n_cnt;
    logic                         r_phase, n_phase;
    logic                         take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pajte_pkg::S_IDLE;
            r_cnt   <= '0;
            r_phase <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_phase <= n_phase;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_phase = r_phase;
        take    = 1'b0;
        o_load  = 1'b0;
        unique case (r_state)
            pajte_pkg::S_IDLE: begin
                if (i_valid) begin
                    take    = 1'b1;
                    n_state = pajte_pkg::S_DIV;
                    n_cnt   = '0;
                    n_phase = 1'b0;
                end
            end
            pajte_pkg::S_DIV: begin
                if (r_cnt == DIV_LAST) begin
                    n_state = pajte_pkg::S_CEIL;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            pajte_pkg::S_CEIL:  n_state = pajte_pkg::S_DUR;
            pajte_pkg::S_DUR:   n_state = pajte_pkg::S_START;
            pajte_pkg::S_START: n_state = pajte_pkg::S_END;
            pajte_pkg::S_END:   n_state = pajte_pkg::S_ON;
            pajte_pkg::S_ON:    n_state = pajte_pkg::S_SPAN;
            pajte_pkg::S_SPAN:  n_state = pajte_pkg::S_OFF;
            pajte_pkg::S_OFF:   n_state = pajte_pkg::S_PB;
            pajte_pkg::S_PB:    n_state = pajte_pkg::S_PA;
            pajte_pkg::S_PA: begin
                n_state = pajte_pkg::S_PM;
                n_cnt   = '0;
            end
            pajte_pkg::S_PM:    n_state = pajte_pkg::S_PC;
            pajte_pkg::S_PC: begin
                if (r_cnt == MAC_LAST) begin
                    n_state = pajte_pkg::S_PSAT;
                    n_cnt   = '0;
                end else begin
                    n_state = pajte_pkg::S_PM;
                    n_cnt   = r_cnt + 1'b1;
                end
            end
            pajte_pkg::S_PSAT: begin
                n_state = i_sat ? pajte_pkg::S_PADD : pajte_pkg::S_PD6;
                n_cnt   = '0;
            end
            pajte_pkg::S_PD6: begin
                if (r_cnt == D6_LAST) begin
                    n_state = pajte_pkg::S_PADD;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            pajte_pkg::S_PADD: begin
                if (!r_phase) begin
                    n_phase = 1'b1;
                    n_state = pajte_pkg::S_PB;
                end else begin
                    n_state = pajte_pkg::S_DONE;
                end
            end
            pajte_pkg::S_DONE: begin
                if (i_out_free) begin
                    o_load  = 1'b1;
                    n_state = pajte_pkg::S_IDLE;
                end
            end
            default: n_state = pajte_pkg::S_IDLE;
        endcase
    end

    assign o_ready      = (r_state == pajte_pkg::S_IDLE);
    assign o_ctrl.state = r_state;
    assign o_ctrl.cnt   = r_cnt;
    assign o_ctrl.phase = r_phase;
    assign o_ctrl.take  = take;

endmodule

`default_nettype wire

[rtl/pajte_dp.sv]
// Datapath: shared add/subtract unit, 32x16 multiplier, divide-by-six step, job state.
`default_nettype none

module pajte_dp #(
    parameter int TIME_BITS = 24
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire pajte_pkg::t_ctrl              i_ctrl,
    input  wire pajte_pkg::t_cfg               i_cfg,
    input  wire logic                          i_first_of_schedule,
    input  wire logic                          i_first_of_machine,
    input  wire logic [pajte_pkg::FIELD_W-1:0] i_setup_time,
    input  wire logic [pajte_pkg::FIELD_W-1:0] i_base_processing_time,
    input  wire logic [pajte_pkg::FIELD_W-1:0] i_speed,
    input  wire logic [pajte_pkg::FIELD_W-1:0] i_consumption_factor,
    input  wire logic [pajte_pkg::FIELD_W-1:0] i_machine_power,
    output logic                               o_sat,
    output pajte_pkg::t_result                 o_result
);

    localparam int FW  = pajte_pkg::FIELD_W;
    localparam int TW  = (TIME_BITS > pajte_pkg::PEAK_W) ? TIME_BITS : pajte_pkg::PEAK_W;
    localparam int QW  = pajte_pkg::DIV_STEPS;
    localparam int AW  = ((TW > QW) ? TW : QW) + 1;
    localparam int XW  = pajte_pkg::MUL_X_W;
    localparam int PW  = pajte_pkg::MUL_P_W;
    localparam int CW  = pajte_pkg::COST_W;
    localparam int SW  = pajte_pkg::TOTAL_W;
    localparam int ACW = pajte_pkg::ACC_W;
    localparam int UW  = pajte_pkg::QUO_W;
    localparam int FB  = pajte_pkg::FRAC_BITS;
    localparam logic [AW-1:0] TMAX = AW'((64'd1 << TIME_BITS) - 64'd1);

    // job registers
    logic [FW-1:0]  r_setup, r_cf, r_pw, r_speed, r_rem;
    logic [QW-1:0]  r_div;
    logic [TW-1:0]  r_prev_in, r_proc, r_dur, r_start, r_end, r_on, r_off;
    logic [CW-1:0]  r_a, r_cost, r_on_cost, r_off_cost;
    logic [XW-1:0]  r_b;
    logic [PW-1:0]  r_prod;
    logic [ACW-1:0] r_acc;
    logic [UW-1:0]  r_q;
    logic [2:0]     r_r6;

    // schedule state
    logic [TW-1:0]  r_prev, r_mk;
    logic [SW-1:0]  r_total;

    // shared add/subtract unit
    logic [AW-1:0]  alu_a, alu_b, alu_res;
    logic           alu_sub, alu_carry;
    logic [AW:0]    alu_sum;
    logic [TW-1:0]  alu_sat;
    logic [FW:0]    div_rs;
    logic [TW-1:0]  ps_t, pe_t, lo, hi, on_val;
    logic           defer;

    // multiplier
    logic [XW-1:0]  mul_x;
    logic [FW-1:0]  mul_y;
    logic [PW-1:0]  mul_p;
    logic [TW-1:0]  part;
    logic [5:0]     mac_shift;

    // divide-by-six step
    logic [10:0]    d6_x, d6_six, d6_rem;
    logic [20:0]    d6_recip;
    logic [7:0]     d6_qd;
    logic [SW:0]    tot_sum;

    assign ps_t   = TW'(i_cfg.peak_start);
    assign pe_t   = TW'(i_cfg.peak_end);
    assign div_rs = {r_rem, r_div[QW-1]};
    assign lo     = (r_start > ps_t) ? r_start : ps_t;
    assign hi     = (r_end < pe_t) ? r_end : pe_t;

    always_comb begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        unique case (i_ctrl.state)
            pajte_pkg::S_DIV: begin
                alu_a   = AW'(div_rs);
                alu_b   = AW'(r_speed);
                alu_sub = 1'b1;
            end
            pajte_pkg::S_CEIL: begin
                alu_a = AW'(r_div);
                alu_b = AW'(r_rem != '0);
            end
            pajte_pkg::S_DUR: begin
                alu_a = AW'(r_setup);
                alu_b = AW'(r_proc);
            end
            pajte_pkg::S_START: begin
                alu_a = AW'(r_prev_in);
                alu_b = AW'(r_dur);
            end
            pajte_pkg::S_END: begin
                alu_a = AW'(r_start);
                alu_b = AW'(r_dur);
            end
            pajte_pkg::S_ON: begin
                alu_a   = AW'(hi);
                alu_b   = AW'(lo);
                alu_sub = 1'b1;
            end
            pajte_pkg::S_SPAN: begin
                alu_a   = AW'(r_end);
                alu_b   = AW'(r_start);
                alu_sub = 1'b1;
            end
            pajte_pkg::S_OFF: begin
                alu_a   = AW'(r_off);
                alu_b   = AW'(r_on);
                alu_sub = 1'b1;
            end
            default: ;
        endcase
    end

    assign alu_sum   = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)} + (AW+1)'(alu_sub);
    assign alu_res   = alu_sum[AW-1:0];
    assign alu_carry = alu_sum[AW];
    assign alu_sat   = (alu_res > TMAX) ? TMAX[TW-1:0] : alu_res[TW-1:0];
    // defer the start past the window when the job would run into its start
    assign defer     = (r_prev_in < ps_t) && (alu_res > AW'(ps_t));
    assign on_val    = ((pe_t >= ps_t) && alu_carry && (alu_res != '0)) ? alu_res[TW-1:0] : '0;

    assign part      = i_ctrl.phase ? r_off : r_on;
    assign mac_shift = {i_ctrl.cnt[1], i_ctrl.cnt[0], 4'b0000};

    always_comb begin
        mul_x = '0;
        mul_y = '0;
        unique case (i_ctrl.state)
            pajte_pkg::S_PB: begin
                mul_x = XW'(r_pw);
                mul_y = i_ctrl.phase ? i_cfg.rate_off_peak : i_cfg.rate_on_peak;
            end
            pajte_pkg::S_PA: begin
                mul_x = XW'(part);
                mul_y = r_cf;
            end
            pajte_pkg::S_PM: begin
                mul_x = i_ctrl.cnt[1] ? XW'(r_a[CW-1:XW]) : r_a[XW-1:0];
                mul_y = i_ctrl.cnt[0] ? r_b[XW-1:FW] : r_b[FW-1:0];
            end
            default: ;
        endcase
    end

    assign mul_p = PW'(mul_x) * PW'(mul_y);

    // saturate once the scaled product reaches six times the cost range
    assign o_sat = (|r_acc[ACW-1:FB+CW+3]) | (r_acc[FB+CW+2] & r_acc[FB+CW+1]);

    assign d6_x     = {r_r6, r_q[UW-1:UW-8]};
    assign d6_recip = 21'(d6_x) * 21'(pajte_pkg::RECIP6);
    assign d6_qd    = d6_recip[19:12];
    assign d6_six   = {1'b0, d6_qd, 2'b00} + {2'b00, d6_qd, 1'b0};
    assign d6_rem   = d6_x - d6_six;

    assign tot_sum  = {1'b0, r_total} + (SW+1)'(r_cost);

    // schedule state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev  <= '0;
            r_mk    <= '0;
            r_total <= '0;
        end else begin
            if (i_ctrl.take && i_first_of_schedule) begin
                r_mk    <= '0;
                r_total <= '0;
            end
            if (i_ctrl.state == pajte_pkg::S_END) begin
                r_prev <= alu_sat;
                if (alu_sat > r_mk) begin
                    r_mk <= alu_sat;
                end
            end
            if (i_ctrl.state == pajte_pkg::S_PADD) begin
                r_total <= tot_sum[SW] ? {SW{1'b1}} : tot_sum[SW-1:0];
            end
        end
    end

    // job datapath
    always_ff @(posedge i_clk) begin
        if (i_ctrl.take) begin
            r_setup   <= i_setup_time;
            r_cf      <= i_consumption_factor;
            r_pw      <= i_machine_power;
            r_speed   <= (i_speed == '0) ? FW'(1) : i_speed;
            r_div     <= {i_base_processing_time, {FB{1'b0}}};
            r_rem     <= '0;
            r_prev_in <= i_first_of_machine ? '0 : r_prev;
        end
        unique case (i_ctrl.state)
            pajte_pkg::S_DIV: begin
                r_div <= {r_div[QW-2:0], alu_carry};
                r_rem <= alu_carry ? alu_res[FW-1:0] : div_rs[FW-1:0];
            end
            pajte_pkg::S_CEIL:  r_proc  <= alu_sat;
            pajte_pkg::S_DUR:   r_dur   <= alu_sat;
            pajte_pkg::S_START: r_start <= defer ? pe_t : r_prev_in;
            pajte_pkg::S_END:   r_end   <= alu_sat;
            pajte_pkg::S_ON:    r_on    <= on_val;
            pajte_pkg::S_SPAN:  r_off   <= alu_res[TW-1:0];
            pajte_pkg::S_OFF:   r_off   <= alu_res[TW-1:0];
            pajte_pkg::S_PB:    r_b     <= mul_p[XW-1:0];
            pajte_pkg::S_PA: begin
                r_a   <= mul_p;
                r_acc <= '0;
            end
            pajte_pkg::S_PM:    r_prod  <= mul_p;
            pajte_pkg::S_PC:    r_acc   <= r_acc + (ACW'(r_prod) << mac_shift);
            pajte_pkg::S_PSAT: begin
                r_cost <= {CW{1'b1}};
                r_q    <= UW'(r_acc[FB+CW+2:FB]);
                r_r6   <= '0;
            end
            pajte_pkg::S_PD6: begin
                r_q    <= {r_q[UW-9:0], d6_qd};
                r_r6   <= d6_rem[2:0];
                r_cost <= {r_q[CW-9:0], d6_qd};
            end
            pajte_pkg::S_PADD: begin
                if (i_ctrl.phase) begin
                    r_off_cost <= r_cost;
                end else begin
                    r_on_cost <= r_cost;
                end
            end
            default: ;
        endcase
    end

    assign o_result.start_time    = r_start[pajte_pkg::OUT_TIME_W-1:0];
    assign o_result.end_time      = r_end[pajte_pkg::OUT_TIME_W-1:0];
    assign o_result.on_peak_cost  = r_on_cost;
    assign o_result.off_peak_cost = r_off_cost;
    assign o_result.makespan      = r_mk[pajte_pkg::OUT_TIME_W-1:0];
    assign o_result.total_cost    = r_total;

endmodule

`default_nettype wire

[rtl/peak_aware_job_timing_energy.sv]
// Top level of the peak-aware job timing and energy block: config, handshake, result register.
//
// Usage:
//   Input channel (i_valid / o_ready) takes one job request per machine in sequence
//   order. Output channel (o_valid / i_ready) returns one result per job: start and end
//   time, on-peak and off-peak cost, makespan and running total cost.
//   Configuration writes (i_cfg_wr_en, i_cfg_addr, i_cfg_wdata) take effect at once and
//   are to be issued only while the block is idle; the block itself does not enforce this.
// Operation:
//   After acceptance a job passes through the bit-serial ceiling division of the
//   processing time, the timing steps on the shared adder, the two prices (cut short
//   when a price saturates) and the load of the result register.
//   The adder is reused for every division and timing step and the 32x16 multiplier for
//   every pricing step, so one request is in flight at a time; o_ready returns in the
//   cycle after the result is loaded, and a new request is taken only then.
// Reset:
//   Synchronous, active low. Clears the schedule state and restores register defaults.
// Stalls:
//   A finished result sits in the output register; the next request is accepted and
//   processed meanwhile and waits in its last step until the register frees up.
`default_nettype none

module peak_aware_job_timing_energy #(
    parameter int TIME_BITS  = 24,
    parameter int MODE_COUNT = 3
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // configuration port
    input  wire logic                                i_cfg_wr_en,
    input  wire logic [pajte_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  wire logic [pajte_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    // request channel
    input  wire logic                                i_valid,
    output logic                                     o_ready,
    input  wire logic                                i_first_of_schedule,
    input  wire logic                                i_first_of_machine,
    input  wire logic [pajte_pkg::FIELD_W-1:0]       i_setup_time,
    input  wire logic [pajte_pkg::FIELD_W-1:0]       i_base_processing_time,
    input  wire logic [1:0]                          i_mode,
    input  wire logic [pajte_pkg::FIELD_W-1:0]       i_consumption_factor,
    input  wire logic [pajte_pkg::FIELD_W-1:0]       i_machine_power,
    // result channel
    output logic                                     o_valid,
    input  wire logic                                i_ready,
    output logic [pajte_pkg::OUT_TIME_W-1:0]         o_start_time,
    output logic [pajte_pkg::OUT_TIME_W-1:0]         o_end_time,
    output logic [pajte_pkg::COST_W-1:0]             o_on_peak_cost,
    output logic [pajte_pkg::COST_W-1:0]             o_off_peak_cost,
    output logic [pajte_pkg::OUT_TIME_W-1:0]         o_makespan,
    output logic [pajte_pkg::TOTAL_W-1:0]            o_total_cost
);

    // configuration registers
    pajte_pkg::t_cfg                 r_cfg;
    logic [pajte_pkg::FIELD_W-1:0]   r_speed [MODE_COUNT];
    logic [pajte_pkg::FIELD_W-1:0]   speed_sel;

    // control between sequencer and datapath
    pajte_pkg::t_ctrl                ctrl;
    pajte_pkg::t_result              dp_result;
    pajte_pkg::t_result              r_out;
    logic                            r_out_valid;
    logic                            out_free;
    logic                            load;
    logic                            sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.peak_start    <= '0;
            r_cfg.peak_end      <= '0;
            r_cfg.rate_on_peak  <= pajte_pkg::RATE_RESET;
            r_cfg.rate_off_peak <= pajte_pkg::RATE_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                pajte_pkg::REG_PEAK_START:    r_cfg.peak_start    <= i_cfg_wdata;
                pajte_pkg::REG_PEAK_END:      r_cfg.peak_end      <= i_cfg_wdata;
                pajte_pkg::REG_RATE_ON_PEAK:
                    r_cfg.rate_on_peak  <= i_cfg_wdata[pajte_pkg::RATE_W-1:0];
                pajte_pkg::REG_RATE_OFF_PEAK:
                    r_cfg.rate_off_peak <= i_cfg_wdata[pajte_pkg::RATE_W-1:0];
                default: ;
            endcase
        end
    end

    // one speed factor register per operating mode, at consecutive indexes
    for (genvar g = 0; g < MODE_COUNT; g++) begin : g_speed
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_speed[g] <= pajte_pkg::SPEED_RESET;
            end else if (i_cfg_wr_en &&
                         i_cfg_addr == pajte_pkg::REG_SPEED_MODE0 +
                                       pajte_pkg::CFG_ADDR_W'(g)) begin
                r_speed[g] <= i_cfg_wdata[pajte_pkg::FIELD_W-1:0];
            end
        end
    end

    // modes beyond the configured count fall back to mode 0
    always_comb begin
        speed_sel = r_speed[0];
        for (int m = 0; m < MODE_COUNT; m++) begin
            if (i_mode == 2'(m)) begin
                speed_sel = r_speed[m];
            end
        end
    end

    assign out_free = !r_out_valid || i_ready;

    pajte_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_out_free (out_free),
        .i_sat      (sat),
        .o_ctrl     (ctrl),
        .o_ready    (o_ready),
        .o_load     (load)
    );

    pajte_dp #(
        .TIME_BITS (TIME_BITS)
    ) u_dp (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_ctrl                 (ctrl),
        .i_cfg                  (r_cfg),
        .i_first_of_schedule    (i_first_of_schedule),
        .i_first_of_machine     (i_first_of_machine),
        .i_setup_time           (i_setup_time),
        .i_base_processing_time (i_base_processing_time),
        .i_speed                (speed_sel),
        .i_consumption_factor   (i_consumption_factor),
        .i_machine_power        (i_machine_power),
        .o_sat                  (sat),
        .o_result               (dp_result)
    );

    // result register: hold until taken, refill from the finished job
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= dp_result;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_start_time    = r_out.start_time;
    assign o_end_time      = r_out.end_time;
    assign o_on_peak_cost  = r_out.on_peak_cost;
    assign o_off_peak_cost = r_out.off_peak_cost;
    assign o_makespan      = r_out.makespan;
    assign o_total_cost    = r_out.total_cost;

endmodule

`default_nettype wire
